// ----- hdl/gtg_pkg.sv -----
`default_nettype none

package gtg_pkg;

    localparam int POS_W   = 16;
    localparam int HDG_W   = 15;
    localparam int SPD_W   = 15;
    localparam int RATE_W  = 16;
    localparam int CFG_W   = 16;
    localparam int REG_IDX_W = 3;

    localparam int TABLE_LEN = 24;
    localparam int CNT_W   = 5;
    localparam int XY_W    = 28;
    localparam int Z_W     = 20;
    localparam int E_W     = 21;
    localparam int ERR_W   = 17;
    localparam int DIST_W  = 18;
    localparam int MA_W    = 26;
    localparam int MB_W    = 16;
    localparam int PROD_W  = MA_W + MB_W;

    localparam logic [MB_W-1:0]       INV_GAIN   = 16'd39797;
    localparam logic signed [Z_W-1:0] HALF_PI    = 20'sd102944;
    localparam logic signed [E_W-1:0] PI_Q16     = 21'sd205887;
    localparam logic signed [E_W-1:0] TWO_PI_Q16 = 21'sd411775;
    localparam logic signed [ERR_W-1:0] TURN_LIMIT = 17'sd410;

    localparam logic signed [POS_W-1:0] RST_GOAL_X   = 16'sd5120;
    localparam logic signed [POS_W-1:0] RST_GOAL_Y   = 16'sd5120;
    localparam logic [15:0]             RST_GAIN     = 16'd4096;
    localparam logic [SPD_W-1:0]        RST_LIMIT    = 15'd2048;
    localparam logic [SPD_W-1:0]        RST_RADIUS   = 15'd51;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_GOAL_X        = 3'd0,
        REG_GOAL_Y        = 3'd1,
        REG_SPEED_GAIN    = 3'd2,
        REG_SPEED_LIMIT   = 3'd3,
        REG_ARRIVE_RADIUS = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ITER,
        S_SCALE,
        S_DIST,
        S_SPEED,
        S_EMIT
    } t_state;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [CNT_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 20'sd51472;
            5'd1:    v = 20'sd30385;
            5'd2:    v = 20'sd16055;
            5'd3:    v = 20'sd8150;
            5'd4:    v = 20'sd4091;
            5'd5:    v = 20'sd2047;
            5'd6:    v = 20'sd1024;
            5'd7:    v = 20'sd512;
            5'd8:    v = 20'sd256;
            5'd9:    v = 20'sd128;
            5'd10:   v = 20'sd64;
            5'd11:   v = 20'sd32;
            5'd12:   v = 20'sd16;
            5'd13:   v = 20'sd8;
            5'd14:   v = 20'sd4;
            5'd15:   v = 20'sd2;
            5'd16:   v = 20'sd1;
            default: v = 20'sd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gtg_pose_if.sv -----
`default_nettype none

interface gtg_pose_if;
    logic                                valid;
    logic                                ready;
    logic signed [gtg_pkg::POS_W-1:0]    pose_x;
    logic signed [gtg_pkg::POS_W-1:0]    pose_y;
    logic signed [gtg_pkg::HDG_W-1:0]    heading;

    modport source (output valid, output pose_x, output pose_y, output heading, input ready);
    modport sink   (input valid, input pose_x, input pose_y, input heading, output ready);
endinterface

`default_nettype wire

// ----- hdl/gtg_cmd_if.sv -----
`default_nettype none

interface gtg_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [gtg_pkg::SPD_W-1:0]           linear_speed;
    logic signed [gtg_pkg::RATE_W-1:0]   turn_rate;
    logic                                arrived;

    modport source (output valid, output linear_speed, output turn_rate, output arrived,
                    input ready);
    modport sink   (input valid, input linear_speed, input turn_rate, input arrived,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/go_to_goal_point_controller.sv -----
// An accepted pose word runs min(CORDIC_STEPS,24) CORDIC micro-rotations, one per cycle, then
// the scale, distance, speed and emit states; emit loads its command word once the output is free.
// Input is ready only while idle, so a new pose word is taken only after the last one is emitted.
// A finished command waits in an output register while the next pose is taken.
// Reset (synchronous, active low) restores the goal registers and clears the stopped latch.
// After the arrival word, pose words are taken and dropped until reset.
`default_nettype none

module go_to_goal_point_controller #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [gtg_pkg::REG_IDX_W-1:0]     i_cfg_idx,
    input  logic [gtg_pkg::CFG_W-1:0]         i_cfg_data,
    gtg_pose_if.sink                          i_pose,
    gtg_cmd_if.source                         o_cmd
);

    localparam int STEPS = (CORDIC_STEPS > gtg_pkg::TABLE_LEN) ?
                           gtg_pkg::TABLE_LEN : CORDIC_STEPS;
    localparam logic [gtg_pkg::CNT_W-1:0] LAST = gtg_pkg::CNT_W'(STEPS - 1);

    gtg_pkg::t_state r_state, n_state;

    logic signed [gtg_pkg::POS_W-1:0]   r_goal_x, r_goal_y;
    logic [15:0]                        r_gain;
    logic [gtg_pkg::SPD_W-1:0]          r_limit, r_radius;
    logic                               r_stopped, n_stopped;
    logic                               r_out_valid, n_out_valid;

    logic signed [gtg_pkg::XY_W-1:0]    r_x, n_x, r_y, n_y;
    logic signed [gtg_pkg::Z_W-1:0]     r_z, n_z;
    logic signed [gtg_pkg::HDG_W-1:0]   r_hd, n_hd;
    logic [gtg_pkg::CNT_W-1:0]          r_cnt, n_cnt;
    logic [gtg_pkg::PROD_W-1:0]         r_prod, n_prod;
    logic [gtg_pkg::DIST_W-1:0]         r_dist, n_dist;
    logic signed [gtg_pkg::ERR_W-1:0]   r_err, n_err;
    logic [gtg_pkg::SPD_W-1:0]          r_speed, n_speed;
    logic signed [gtg_pkg::RATE_W-1:0]  r_rate, n_rate;
    logic                               r_arrived, n_arrived;

    logic signed [16:0]                 dx, dy;
    logic signed [gtg_pkg::XY_W-1:0]    dxs, dys;
    logic signed [gtg_pkg::XY_W-1:0]    sx, sy;
    logic [gtg_pkg::MA_W-1:0]           mul_a;
    logic [gtg_pkg::MB_W-1:0]           mul_b;
    logic [gtg_pkg::PROD_W-1:0]         rnd;
    logic signed [gtg_pkg::E_W-1:0]     e0, e1, e2;
    logic signed [17:0]                 rate2;
    logic [34:0]                        sp_rnd;
    logic [22:0]                        sp;
    logic                               is_arrive, is_turn, out_free, accept;

    assign i_pose.ready      = (r_state == gtg_pkg::S_IDLE);
    assign accept            = i_pose.valid && i_pose.ready;
    assign out_free          = !r_out_valid || o_cmd.ready;

    assign o_cmd.valid        = r_out_valid;
    assign o_cmd.linear_speed = r_speed;
    assign o_cmd.turn_rate    = r_rate;
    assign o_cmd.arrived      = r_arrived;

    always_comb begin
        dx  = {r_goal_x[15], r_goal_x} - {i_pose.pose_x[15], i_pose.pose_x};
        dy  = {r_goal_y[15], r_goal_y} - {i_pose.pose_y[15], i_pose.pose_y};
        dxs = {{3{dx[16]}}, dx, 8'b0};
        dys = {{3{dy[16]}}, dy, 8'b0};
        sx  = r_x >>> r_cnt;
        sy  = r_y >>> r_cnt;

        mul_a = (r_state == gtg_pkg::S_SPEED) ? gtg_pkg::MA_W'(r_dist) : r_x[gtg_pkg::MA_W-1:0];
        mul_b = (r_state == gtg_pkg::S_SPEED) ? r_gain : gtg_pkg::INV_GAIN;

        rnd = r_prod + gtg_pkg::PROD_W'(1 << 23);

        e0 = {r_z[gtg_pkg::Z_W-1], r_z} - {{2{r_hd[gtg_pkg::HDG_W-1]}}, r_hd, 4'b0};
        if (e0 > gtg_pkg::PI_Q16) begin
            e1 = e0 - gtg_pkg::TWO_PI_Q16;
        end else if (e0 < -gtg_pkg::PI_Q16) begin
            e1 = e0 + gtg_pkg::TWO_PI_Q16;
        end else begin
            e1 = e0;
        end
        e2 = e1 + 21'sd8;

        is_arrive = r_dist <= {3'b0, r_radius};
        is_turn   = (r_err > gtg_pkg::TURN_LIMIT) || (r_err < -gtg_pkg::TURN_LIMIT);
        rate2     = {r_err, 1'b0};
        sp_rnd    = {1'b0, r_prod[33:0]} + 35'd2048;
        sp        = sp_rnd[34:12];
    end

    always_comb begin
        n_state     = r_state;
        n_stopped   = r_stopped;
        n_out_valid = r_out_valid && !o_cmd.ready;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_hd        = r_hd;
        n_cnt       = r_cnt;
        n_prod      = r_prod;
        n_dist      = r_dist;
        n_err       = r_err;
        n_speed     = r_speed;
        n_rate      = r_rate;
        n_arrived   = r_arrived;

        case (r_state)
            gtg_pkg::S_IDLE: begin
                if (accept && !r_stopped) begin
                    n_hd  = i_pose.heading;
                    n_cnt = '0;
                    if (dx[16]) begin
                        if (!dy[16]) begin
                            n_x = dys;
                            n_y = -dxs;
                            n_z = gtg_pkg::HALF_PI;
                        end else begin
                            n_x = -dys;
                            n_y = dxs;
                            n_z = -gtg_pkg::HALF_PI;
                        end
                    end else begin
                        n_x = dxs;
                        n_y = dys;
                        n_z = '0;
                    end
                    n_state = gtg_pkg::S_ITER;
                end
            end
            gtg_pkg::S_ITER: begin
                if (!r_y[gtg_pkg::XY_W-1]) begin
                    n_x = r_x + sy;
                    n_y = r_y - sx;
                    n_z = r_z + gtg_pkg::atan_q16(r_cnt);
                end else begin
                    n_x = r_x - sy;
                    n_y = r_y + sx;
                    n_z = r_z - gtg_pkg::atan_q16(r_cnt);
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_state = gtg_pkg::S_SCALE;
                end
            end
            gtg_pkg::S_SCALE: begin
                n_prod  = mul_a * mul_b;
                n_state = gtg_pkg::S_DIST;
            end
            gtg_pkg::S_DIST: begin
                n_dist  = rnd[gtg_pkg::PROD_W-1:24];
                n_err   = e2[gtg_pkg::E_W-1:4];
                n_state = gtg_pkg::S_SPEED;
            end
            gtg_pkg::S_SPEED: begin
                n_prod  = mul_a * mul_b;
                n_state = gtg_pkg::S_EMIT;
            end
            gtg_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_speed     = '0;
                    n_rate      = '0;
                    n_arrived   = 1'b0;
                    if (is_arrive) begin
                        n_arrived = 1'b1;
                        n_stopped = 1'b1;
                    end else if (is_turn) begin
                        if (rate2 > 18'sd32767) begin
                            n_rate = 16'sh7FFF;
                        end else if (rate2 < -18'sd32768) begin
                            n_rate = 16'sh8000;
                        end else begin
                            n_rate = rate2[15:0];
                        end
                    end else if (sp > {8'b0, r_limit}) begin
                        n_speed = r_limit;
                    end else begin
                        n_speed = sp[gtg_pkg::SPD_W-1:0];
                    end
                    n_state = gtg_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gtg_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gtg_pkg::S_IDLE;
            r_stopped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_stopped   <= n_stopped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= gtg_pkg::RST_GOAL_X;
            r_goal_y <= gtg_pkg::RST_GOAL_Y;
            r_gain   <= gtg_pkg::RST_GAIN;
            r_limit  <= gtg_pkg::RST_LIMIT;
            r_radius <= gtg_pkg::RST_RADIUS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gtg_pkg::REG_GOAL_X:        r_goal_x <= i_cfg_data;
                gtg_pkg::REG_GOAL_Y:        r_goal_y <= i_cfg_data;
                gtg_pkg::REG_SPEED_GAIN:    r_gain   <= i_cfg_data;
                gtg_pkg::REG_SPEED_LIMIT:   r_limit  <= i_cfg_data[gtg_pkg::SPD_W-1:0];
                gtg_pkg::REG_ARRIVE_RADIUS: r_radius <= i_cfg_data[gtg_pkg::SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_x       <= n_x;
        r_y       <= n_y;
        r_z       <= n_z;
        r_hd      <= n_hd;
        r_cnt     <= n_cnt;
        r_prod    <= n_prod;
        r_dist    <= n_dist;
        r_err     <= n_err;
        r_speed   <= n_speed;
        r_rate    <= n_rate;
        r_arrived <= n_arrived;
    end

`ifndef SYNTHESIS
    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped latch cleared without reset");

    a_arrival_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.valid && o_cmd.arrived) |-> (o_cmd.linear_speed == '0 && o_cmd.turn_rate == '0))
        else $error("arrival word carries a nonzero command");

    a_drive_or_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.valid |-> (o_cmd.linear_speed == '0 || o_cmd.turn_rate == '0))
        else $error("word both drives and turns");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gtg_pkg::S_ITER) |-> (r_cnt <= LAST))
        else $error("CORDIC step count overran");

    a_silent_after_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stopped && !r_out_valid) |=> !r_out_valid)
        else $error("word emitted after arrival");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_go_to_goal_point_controller.sv -----
`default_nettype none

module tb_go_to_goal_point_controller;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     STEPS      = 16;
    localparam int     ROUNDS     = (STEPS > 24) ? 24 : STEPS;
    localparam int     DRAIN      = 40;
    localparam int     HOLD_AT    = 100;
    localparam int     HOLD_LEN   = 400;
    localparam longint GUARD      = 256;
    localparam longint INV_K      = 39797;
    localparam longint QTR_TURN   = 102944;
    localparam longint HALF_TURN  = 205887;
    localparam longint FULL_TURN  = 411775;
    localparam longint TURN_MIN   = 410;
    localparam longint ROUND_24   = 64'd8388608;

    localparam logic [gtg_pkg::REG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [gtg_pkg::REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint ARCTAN [24] = '{
        51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0
    };

    typedef struct {
        logic signed [gtg_pkg::POS_W-1:0] x;
        logic signed [gtg_pkg::POS_W-1:0] y;
        logic signed [gtg_pkg::HDG_W-1:0] heading;
    } t_pose_word;

    typedef struct {
        logic [gtg_pkg::SPD_W-1:0]         speed;
        logic signed [gtg_pkg::RATE_W-1:0] rate;
        logic                              arrived;
    } t_cmd_word;

    typedef enum {PICK_ANY, PICK_AIMED, PICK_NEAR} t_pick;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [gtg_pkg::REG_IDX_W-1:0]   i_cfg_idx;
    logic [gtg_pkg::CFG_W-1:0]       i_cfg_data;

    gtg_pose_if pose_ch ();
    gtg_cmd_if  cmd_ch ();

    go_to_goal_point_controller #(
        .CORDIC_STEPS (STEPS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pose     (pose_ch),
        .o_cmd      (cmd_ch)
    );

    logic signed [gtg_pkg::POS_W-1:0] cfg_goal_x = gtg_pkg::RST_GOAL_X;
    logic signed [gtg_pkg::POS_W-1:0] cfg_goal_y = gtg_pkg::RST_GOAL_Y;
    logic [15:0]                      cfg_gain   = gtg_pkg::RST_GAIN;
    logic [gtg_pkg::SPD_W-1:0]        cfg_limit  = gtg_pkg::RST_LIMIT;
    logic [gtg_pkg::SPD_W-1:0]        cfg_radius = gtg_pkg::RST_RADIUS;
    logic                             halted     = 1'b0;

    t_pose_word pose_backlog [$];
    t_cmd_word  cmd_due [$];

    int poses_queued = 0;
    int poses_taken  = 0;
    int cmds_seen    = 0;
    int fail_cnt     = 0;
    int n_turn       = 0;
    int n_drive      = 0;
    int n_arrive     = 0;
    int send_gap_pct = 20;
    int take_gap_pct = 20;
    int send_gap;
    int take_gap;
    int hold_left;
    logic hold_done;

    always #4 i_clk = ~i_clk;

    function automatic void range_bearing(input int px, input int py,
                                          output longint distance, output longint bearing);
        longint dx, dy, x, y, z, t;
        dx = (longint'(cfg_goal_x) - px) * GUARD;
        dy = (longint'(cfg_goal_y) - py) * GUARD;
        if (dx < 0) begin
            if (dy >= 0) begin
                x = dy;  y = -dx; z = QTR_TURN;
            end else begin
                x = -dy; y = dx;  z = -QTR_TURN;
            end
        end else begin
            x = dx; y = dy; z = 0;
        end
        for (int i = 0; i < ROUNDS; i++) begin
            t = x;
            if (y >= 0) begin
                x = x + (y >>> i);
                y = y - (t >>> i);
                z = z + ARCTAN[i];
            end else begin
                x = x - (y >>> i);
                y = y + (t >>> i);
                z = z - ARCTAN[i];
            end
        end
        distance = (x * INV_K + ROUND_24) >>> 24;
        bearing  = z;
    endfunction

    function automatic logic steer_cmd(input t_pose_word p, output t_cmd_word c);
        longint distance, bearing, err, rate, spd;
        c.speed   = '0;
        c.rate    = '0;
        c.arrived = 1'b0;
        if (halted)
            return 1'b0;
        range_bearing(int'(p.x), int'(p.y), distance, bearing);
        if (distance <= longint'(cfg_radius)) begin
            halted    = 1'b1;
            c.arrived = 1'b1;
            return 1'b1;
        end
        err = bearing - longint'(p.heading) * 16;
        while (err > HALF_TURN)
            err = err - FULL_TURN;
        while (err < -HALF_TURN)
            err = err + FULL_TURN;
        err = (err + 8) >>> 4;
        if (err > TURN_MIN || err < -TURN_MIN) begin
            rate = 2 * err;
            if (rate > 32767)
                rate = 32767;
            if (rate < -32768)
                rate = -32768;
            c.rate = rate[gtg_pkg::RATE_W-1:0];
        end else begin
            spd = (longint'(cfg_gain) * distance + 2048) >>> 12;
            if (spd > longint'(cfg_limit))
                spd = longint'(cfg_limit);
            c.speed = spd[gtg_pkg::SPD_W-1:0];
        end
        return 1'b1;
    endfunction

    function automatic t_pose_word plan_pose(input t_pick how, input logic aimed);
        t_pose_word p;
        longint     distance, bearing;
        int         px, py, span, h;
        logic       found;
        found = 1'b0;
        px    = 0;
        py    = 0;
        span  = int'(cfg_radius) + 64;
        for (int tries = 0; tries < 24 && !found; tries++) begin
            if (how == PICK_NEAR) begin
                px = int'(cfg_goal_x) + int'($urandom_range(2 * span)) - span;
                py = int'(cfg_goal_y) + int'($urandom_range(2 * span)) - span;
                if (px < -32768 || px > 32767 || py < -32768 || py > 32767)
                    continue;
            end else begin
                px = int'($urandom_range(65535)) - 32768;
                py = int'($urandom_range(65535)) - 32768;
            end
            range_bearing(px, py, distance, bearing);
            found = (distance > longint'(cfg_radius));
        end
        if (!found) begin
            px = (cfg_goal_x < 0) ? 32767 : -32768;
            py = (cfg_goal_y < 0) ? 32767 : -32768;
            range_bearing(px, py, distance, bearing);
        end
        if (how == PICK_AIMED || aimed) begin
            h = int'((bearing + 8) >>> 4) + int'($urandom_range(900)) - 450;
            if (h > 16383)
                h = 16383;
            if (h < -16384)
                h = -16384;
        end else begin
            h = int'($urandom_range(32767)) - 16384;
        end
        p.x       = 16'(px);
        p.y       = 16'(py);
        p.heading = 15'(h);
        return p;
    endfunction

    task automatic add_pose(input int px, input int py, input int h);
        t_pose_word p;
        longint     distance, bearing;
        range_bearing(px, py, distance, bearing);
        if (distance > longint'(cfg_radius)) begin
            p.x       = 16'(px);
            p.y       = 16'(py);
            p.heading = 15'(h);
            pose_backlog.push_back(p);
            poses_queued++;
        end
    endtask

    task automatic write_reg(input logic [gtg_pkg::REG_IDX_W-1:0] idx,
                             input logic [gtg_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            gtg_pkg::REG_GOAL_X:        cfg_goal_x = data;
            gtg_pkg::REG_GOAL_Y:        cfg_goal_y = data;
            gtg_pkg::REG_SPEED_GAIN:    cfg_gain   = data;
            gtg_pkg::REG_SPEED_LIMIT:   cfg_limit  = data[gtg_pkg::SPD_W-1:0];
            gtg_pkg::REG_ARRIVE_RADIUS: cfg_radius = data[gtg_pkg::SPD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_goal(input logic [15:0] gx, input logic [15:0] gy,
                             input logic [15:0] gain, input logic [gtg_pkg::SPD_W-1:0] lim,
                             input logic [gtg_pkg::SPD_W-1:0] rad);
        logic                          noise;
        logic [gtg_pkg::REG_IDX_W-1:0] spare;
        write_reg(gtg_pkg::REG_GOAL_X, gx);
        write_reg(gtg_pkg::REG_GOAL_Y, gy);
        write_reg(gtg_pkg::REG_SPEED_GAIN, gain);
        noise = 1'($urandom);
        write_reg(gtg_pkg::REG_SPEED_LIMIT, {noise, lim});
        noise = 1'($urandom);
        write_reg(gtg_pkg::REG_ARRIVE_RADIUS, {noise, rad});
        spare = 3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO));
        write_reg(spare, 16'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic settle();
        while (poses_taken != poses_queued || cmd_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic run_phase(input int n, input int send_pct, input int take_pct);
        int    r;
        t_pick how;
        send_gap_pct = send_pct;
        take_gap_pct = take_pct;
        repeat (n) begin
            r   = $urandom_range(9);
            how = (r < 5) ? PICK_ANY : (r < 8) ? PICK_AIMED : PICK_NEAR;
            pose_backlog.push_back(plan_pose(how, 1'($urandom_range(1))));
            poses_queued++;
        end
        settle();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pose_ch.valid <= 1'b0;
            send_gap      <= 0;
        end else if (!pose_ch.valid || pose_ch.ready) begin
            if (send_gap > 0) begin
                send_gap      <= send_gap - 1;
                pose_ch.valid <= 1'b0;
            end else if (pose_backlog.size() == 0) begin
                pose_ch.valid <= 1'b0;
            end else if ($urandom_range(99) < send_gap_pct) begin
                send_gap      <= $urandom_range(12);
                pose_ch.valid <= 1'b0;
            end else begin
                pose_ch.valid   <= 1'b1;
                pose_ch.pose_x  <= pose_backlog[0].x;
                pose_ch.pose_y  <= pose_backlog[0].y;
                pose_ch.heading <= pose_backlog[0].heading;
                void'(pose_backlog.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.ready <= 1'b0;
            take_gap     <= 0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            cmd_ch.ready <= 1'b0;
        end else if (!hold_done && cmds_seen >= HOLD_AT) begin
            hold_done    <= 1'b1;
            hold_left    <= HOLD_LEN;
            cmd_ch.ready <= 1'b0;
        end else if (take_gap > 0) begin
            take_gap     <= take_gap - 1;
            cmd_ch.ready <= 1'b0;
        end else if ($urandom_range(99) < take_gap_pct) begin
            take_gap     <= $urandom_range(12);
            cmd_ch.ready <= 1'b0;
        end else begin
            cmd_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : pose_taken
        t_pose_word p;
        t_cmd_word  c;
        if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
            poses_taken++;
            p.x       = pose_ch.pose_x;
            p.y       = pose_ch.pose_y;
            p.heading = pose_ch.heading;
            if (steer_cmd(p, c)) begin
                cmd_due.push_back(c);
                if (c.arrived)
                    n_arrive++;
                else if (c.rate != 0)
                    n_turn++;
                else
                    n_drive++;
            end
        end
    end

    always @(posedge i_clk) begin : cmd_check
        t_cmd_word want;
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            cmds_seen++;
            if (cmd_due.size() == 0) begin
                fail_cnt++;
                $display("%0t: unexpected word speed %0d rate %0d arrived %0d", $time,
                         cmd_ch.linear_speed, cmd_ch.turn_rate, cmd_ch.arrived);
            end else begin
                want = cmd_due.pop_front();
                if (cmd_ch.linear_speed !== want.speed) begin
                    fail_cnt++;
                    $display("%0t: linear_speed expected %0d actual %0d", $time,
                             want.speed, cmd_ch.linear_speed);
                end
                if (cmd_ch.turn_rate !== want.rate) begin
                    fail_cnt++;
                    $display("%0t: turn_rate expected %0d actual %0d", $time,
                             want.rate, cmd_ch.turn_rate);
                end
                if (cmd_ch.arrived !== want.arrived) begin
                    fail_cnt++;
                    $display("%0t: arrived expected %0d actual %0d", $time,
                             want.arrived, cmd_ch.arrived);
                end
            end
        end
    end

    initial begin : stimulus
        t_pose_word p;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = gtg_pkg::REG_GOAL_X;
        i_cfg_data      = '0;
        pose_ch.valid   = 1'b0;
        pose_ch.pose_x  = '0;
        pose_ch.pose_y  = '0;
        pose_ch.heading = '0;
        cmd_ch.ready    = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_pose(-32768, -32768, -16384);
        add_pose(32767, 32767, 16383);
        add_pose(32767, -32768, 0);
        add_pose(-32768, 32767, 0);
        add_pose(10240, 5120, -12868);
        add_pose(10240, 5120, 12867);
        add_pose(10240, 0, 0);
        add_pose(10240, 10240, 0);
        add_pose(0, 5120, 0);
        add_pose(0, 5120, 410);
        add_pose(0, 5120, 411);
        add_pose(0, 5120, -410);
        add_pose(0, 5120, -411);
        add_pose(5000, 5120, 0);
        add_pose(5068, 5120, 0);
        add_pose(5120, 5172, -6434);
        add_pose(5120, 0, 6434);
        add_pose(5120, 10240, -6434);
        add_pose(0, 0, 3217);
        run_phase(0, 20, 20);

        load_goal(16'h7FFF, 16'h8000, 16'hFFFF, 15'h7FFF, '0);
        run_phase(240, 30, 30);
        load_goal(16'h8000, 16'h7FFF, '0, '0, 15'h7FFF);
        run_phase(200, 20, 40);
        for (int ph = 0; ph < 6; ph++) begin
            load_goal(16'($urandom), 16'($urandom), 16'($urandom), 15'($urandom),
                      15'($urandom_range(3000)));
            run_phase(240, (ph == 2 || ph == 5) ? 0 : 25, (ph == 2 || ph == 5) ? 0 : 25);
        end

        // reach the goal, then feed words that must be dropped
        p.x       = cfg_goal_x;
        p.y       = cfg_goal_y;
        p.heading = 15'($urandom);
        pose_backlog.push_back(p);
        poses_queued++;
        repeat (3) begin
            pose_backlog.push_back(plan_pose(PICK_ANY, 1'b0));
            poses_queued++;
        end
        settle();

        $display("covered %0d pose words over 9 goal settings: %0d turning, %0d driving,",
                 poses_taken, n_turn, n_drive);
        $display("%0d arrival, %0d commands checked, one long output stall", n_arrive,
                 cmds_seen);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- go_to_goal_point_controller.f -----
hdl/gtg_pkg.sv
hdl/gtg_pose_if.sv
hdl/gtg_cmd_if.sv
hdl/go_to_goal_point_controller.sv
dv/tb_go_to_goal_point_controller.sv
